[hdl/rwlt_pkg.sv]
// Package for the reader/writer lock table: status codes, opcodes, policy codes, timestamp width and state codes.
// No dependencies.
package rwlt_pkg;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_BUSY    = 3'd1,
      ST_WAIT    = 3'd2,
      ST_INVALID = 3'd3,
      ST_NOTHELD = 3'd4,
      ST_FULL    = 3'd5
   } status_type;

   localparam logic FUNC_ACQUIRE = 1'b0;
   localparam logic FUNC_RELEASE = 1'b1;

   localparam logic [1:0] POL_NO_WAIT    = 2'd0;
   localparam logic [1:0] POL_WAIT_DIE   = 2'd1;
   localparam logic [1:0] POL_WOUND_WAIT = 2'd2;

   localparam int TS_W = 32;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_WOUND,
      S_DONE
   } fsm_type;

endpackage

[hdl/rw_lock_table_2pl.sv]
// Top level of the reader/writer lock table (two-phase locking).
// Uses rwlt_pkg and rwlt_ram.
//
//  channel | dir | fields
//  req_    | in  | tdata: func, entry_index, lock_mode, txn_ts, txn_wounded
//  rsp_    | out | tdata: kind, status, wounded_ts; tlast: last
//  csr_    | in  | data: policy
//
// Each request reads its entry's owner row from memory at the accepting edge,
// decides and writes the row back in the next cycle, then presents any wound
// notices and the final word. Reset is synchronous; entries start empty through
// per-entry valid bits. A stalled rsp_ holds the block.
module rw_lock_table_2pl #(
   parameter int ENTRIES = 256,
   parameter int OWNERS  = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [0] func, [8:1] entry_index, [9] lock_mode, [41:10] txn_ts, [42] txn_wounded
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] kind, [3:1] status, [35:4] wounded_ts
   output logic [39:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_data
);
   import rwlt_pkg::*;

   localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(OWNERS + 1);
   localparam int OW = (OWNERS > 1) ? $clog2(OWNERS) : 1;
   localparam int RW = OWNERS * TS_W;

   fsm_type state_ff, state_in;
   logic [1:0] policy_ff;
   logic [ENTRIES-1:0] vld_ff;

   logic          func_ff, mode_ff, wnd_ff;
   logic [EW-1:0] ent_ff;
   logic [TS_W-1:0] ts_ff;

   logic [RW-1:0] row_rd, row_ff, row_in, row_cur;
   logic [CW-1:0] cnt_rd, cnt_mem, cnt_in;
   logic          exc_rd, exc_mem, exc_in;
   logic          wr_en;
   logic [OW:0]   wi_ff, wi_in;   // wound scan index (count down)
   logic [OW:0]   wlo_ff, wlo_in; // lowest index to wound
   status_type    st_ff, st_in;

   logic [EW-1:0] req_ent;
   assign req_ent = (ENTRIES > 1) ? EW'(req_tdata[8:1] % ENTRIES) : '0;

   rwlt_ram #(.WIDTH(RW), .DEPTH(ENTRIES)) u_rows (
      .clock(clock), .wr_en(wr_en), .wr_addr(ent_ff), .wr_data(row_in),
      .rd_addr(req_ent), .rd_data(row_rd));
   rwlt_ram #(.WIDTH(CW + 1), .DEPTH(ENTRIES)) u_meta (
      .clock(clock), .wr_en(wr_en), .wr_addr(ent_ff), .wr_data({cnt_in, exc_in}),
      .rd_addr(req_ent), .rd_data({cnt_rd, exc_rd}));

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);

   // The memory word is valid only in S_READ; later states use the stored copy.
   assign row_cur = (state_ff == S_READ) ? row_rd : row_ff;

   // Decision on the current owner row.
   logic [TS_W-1:0] own [OWNERS];
   logic hit;
   logic [OW-1:0] pos;
   logic [OW:0] ins;   // insert position
   logic [OW:0] nyng;  // number of owners younger than requester
   logic [CW-1:0] n;

   always_comb begin
      n = (cnt_mem > CW'(OWNERS)) ? CW'(OWNERS) : cnt_mem;
      hit = 1'b0; pos = '0; nyng = '0;
      for (int i = OWNERS - 1; i >= 0; i--) begin
         own[i] = row_cur[i*TS_W +: TS_W];
         if (CW'(i) < n && own[i] == ts_ff) begin
            hit = 1'b1; pos = OW'(i);
         end
         if (CW'(i) < n && own[i] > ts_ff) nyng = nyng + 1'b1;
      end
      ins = (OW+1)'(n) - nyng;
   end

   always_comb begin
      state_in = state_ff;
      row_in = row_cur; cnt_in = cnt_mem; exc_in = exc_mem;
      wr_en = 1'b0; st_in = st_ff; wi_in = wi_ff; wlo_in = wlo_ff;
      unique case (state_ff)
         S_IDLE: if (req_tvalid) state_in = S_READ;
         S_READ: begin
            state_in = S_DONE;
            if (func_ff == FUNC_RELEASE) begin
               if (!hit) st_in = ST_NOTHELD;
               else if (exc_mem != mode_ff) st_in = ST_INVALID;
               else begin
                  st_in = ST_OK; wr_en = 1'b1;
                  for (int i = 0; i < OWNERS - 1; i++)
                     if (OW'(i) >= pos) row_in[i*TS_W +: TS_W] = own[i+1];
                  cnt_in = n - 1'b1;
                  if (n == CW'(1)) exc_in = 1'b0;
               end
            end else if (policy_ff == POL_WOUND_WAIT && wnd_ff) begin
               st_in = ST_BUSY;
            end else if (n == '0) begin
               wr_en = 1'b1; row_in[TS_W-1:0] = ts_ff;
               cnt_in = CW'(1); exc_in = mode_ff; st_in = ST_OK;
            end else if (exc_mem) begin
               if (own[0] == ts_ff) st_in = ST_OK;
               else if (policy_ff == POL_WAIT_DIE)
                  st_in = (own[0] < ts_ff) ? ST_BUSY : ST_WAIT;
               else if (policy_ff == POL_WOUND_WAIT) begin
                  st_in = ST_WAIT;
                  if (own[0] > ts_ff) begin
                     wi_in = (OW+1)'(1); wlo_in = '0; state_in = S_WOUND;
                  end
               end else st_in = ST_BUSY;
            end else if (mode_ff) begin
               if (n == CW'(1) && own[0] == ts_ff) begin
                  wr_en = 1'b1; exc_in = 1'b1; st_in = ST_OK;
               end else if (policy_ff == POL_WAIT_DIE)
                  st_in = (own[0] < ts_ff) ? ST_BUSY : ST_WAIT;
               else if (policy_ff == POL_WOUND_WAIT) begin
                  st_in = ST_WAIT;
                  if (nyng != '0) begin
                     wi_in = (OW+1)'(n); wlo_in = ins; state_in = S_WOUND;
                  end
               end else st_in = ST_BUSY;
            end else begin
               if (hit) st_in = ST_OK;
               else if (n >= CW'(OWNERS)) st_in = ST_FULL;
               else begin
                  wr_en = 1'b1; st_in = ST_OK; cnt_in = n + 1'b1;
                  for (int i = 0; i < OWNERS; i++) begin
                     if ((OW+1)'(i) == ins) row_in[i*TS_W +: TS_W] = ts_ff;
                     else if ((OW+1)'(i) > ins && i > 0)
                        row_in[i*TS_W +: TS_W] = own[i-1];
                  end
               end
            end
         end
         S_WOUND: if (rsp_tready) begin
            wi_in = wi_ff - 1'b1;
            if (wi_ff - 1'b1 == wlo_ff) state_in = S_DONE;
         end
         S_DONE: if (rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   logic [OW-1:0] widx;
   assign widx = OW'(wi_ff - 1'b1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; policy_ff <= POL_NO_WAIT; vld_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) policy_ff <= csr_data;
         if (wr_en) vld_ff[ent_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_tvalid) begin
         func_ff <= req_tdata[0]; ent_ff <= req_ent; mode_ff <= req_tdata[9];
         ts_ff <= req_tdata[41:10]; wnd_ff <= req_tdata[42];
      end
      if (state_ff == S_READ) begin
         // Keep the row for the wound notices that follow.
         row_ff <= row_rd;
      end
      st_ff <= st_in; wi_ff <= wi_in; wlo_ff <= wlo_in;
   end

   // Metadata from memory, masked by the valid bit.
   always_comb begin
      cnt_mem = vld_ff[ent_ff] ? cnt_rd : '0;
      exc_mem = vld_ff[ent_ff] ? exc_rd : 1'b0;
   end

   assign rsp_tvalid = (state_ff == S_WOUND) || (state_ff == S_DONE);
   assign rsp_tlast  = (state_ff == S_DONE);
   assign rsp_tdata  = (state_ff == S_WOUND)
                       ? {4'd0, own[widx], ST_OK, 1'b1}
                       : {4'd0, 32'd0, st_ff, 1'b0};

   a_last_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[0] == 1'b0) else $error("last not status");
   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("ready while responding");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) && rsp_tready |=> state_ff == S_IDLE) else $error("done stuck");
endmodule

[hdl/rwlt_ram.sv]
// Generic single-port-write, single-read synchronous RAM with registered read.
// No dependencies.
module rwlt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[dv/testbench.sv]
// Self-checking testbench for rw_lock_table_2pl: a behavioral lock table predicts the
// result words of each request and a monitor compares them. Depends on rwlt_pkg.
`timescale 1ns / 1ps

module testbench;
   import rwlt_pkg::*;

   localparam int ENTRIES = 256;
   localparam int OWNERS  = 8;

   typedef struct packed {
      logic        wounded;
      logic [31:0] ts;
      logic        mode;
      logic [7:0]  entry;
      logic        func;
   } lock_req_type;

   typedef struct packed {
      logic        kind;
      status_type  status;
      logic [31:0] wounded_ts;
      logic        last;
   } lock_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_data = '0;

   // Predictor state.
   logic [31:0] lt_stamps [ENTRIES][OWNERS];
   int          lt_count [ENTRIES];
   logic        lt_excl [ENTRIES];
   logic [1:0]  lt_policy;

   lock_req_type pending_reqs[$];
   lock_rsp_type expected_rsps[$];
   int          mismatches = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          accepted = 0;
   logic        accepted_flag = 1'b0;

   rw_lock_table_2pl #(.ENTRIES(ENTRIES), .OWNERS(OWNERS)) u_dut (.*);

   always #5 clock = ~clock;

   function automatic void push_rsp(logic kind, status_type st, logic [31:0] wts,
                                    logic last);
      lock_rsp_type r;
      r.kind = kind;
      r.status = st;
      r.wounded_ts = wts;
      r.last = last;
      expected_rsps.push_back(r);
   endfunction

   function automatic void predict_lock(lock_req_type q);
      int e;
      int n;
      int pos;
      int i;
      logic excl;
      status_type st;
      e = q.entry;
      n = lt_count[e];
      excl = lt_excl[e];
      pos = -1;
      for (i = 0; i < n; i++)
         if (pos < 0 && lt_stamps[e][i] == q.ts) pos = i;
      if (q.func == FUNC_RELEASE) begin
         if (pos < 0) st = ST_NOTHELD;
         else if (excl != q.mode) st = ST_INVALID;
         else begin
            for (i = pos; i + 1 < n; i++) lt_stamps[e][i] = lt_stamps[e][i+1];
            lt_count[e] = n - 1;
            if (n == 1) lt_excl[e] = 1'b0;
            st = ST_OK;
         end
         push_rsp(1'b0, st, '0, 1'b1);
         return;
      end
      if (lt_policy == POL_WOUND_WAIT && q.wounded) st = ST_BUSY;
      else if (n == 0) begin
         lt_stamps[e][0] = q.ts;
         lt_count[e] = 1;
         lt_excl[e] = q.mode;
         st = ST_OK;
      end else if (excl) begin
         if (lt_stamps[e][0] == q.ts) st = ST_OK;
         else if (lt_policy == POL_WAIT_DIE)
            st = (lt_stamps[e][0] < q.ts) ? ST_BUSY : ST_WAIT;
         else if (lt_policy == POL_WOUND_WAIT) begin
            if (lt_stamps[e][0] > q.ts) push_rsp(1'b1, ST_OK, lt_stamps[e][0], 1'b0);
            st = ST_WAIT;
         end else st = ST_BUSY;
      end else if (q.mode) begin
         if (n == 1 && lt_stamps[e][0] == q.ts) begin
            lt_excl[e] = 1'b1;
            st = ST_OK;
         end else if (lt_policy == POL_WAIT_DIE)
            st = (lt_stamps[e][0] < q.ts) ? ST_BUSY : ST_WAIT;
         else if (lt_policy == POL_WOUND_WAIT) begin
            // Younger owners are wounded, youngest first.
            for (i = n; i > 0 && lt_stamps[e][i-1] > q.ts; i--)
               push_rsp(1'b1, ST_OK, lt_stamps[e][i-1], 1'b0);
            st = ST_WAIT;
         end else st = ST_BUSY;
      end else begin
         if (pos >= 0) st = ST_OK;
         else if (n >= OWNERS) st = ST_FULL;
         else begin
            i = n;
            while (i > 0 && lt_stamps[e][i-1] > q.ts) begin
               lt_stamps[e][i] = lt_stamps[e][i-1];
               i--;
            end
            lt_stamps[e][i] = q.ts;
            lt_count[e] = n + 1;
            st = ST_OK;
         end
      end
      push_rsp(1'b0, st, '0, 1'b1);
   endfunction

   // Driver: a word stays on the bus until accepted.
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || accepted_flag) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tdata <= {5'b0, pending_reqs.pop_front()};
               req_tvalid <= 1'b1;
            end else
               req_tvalid <= 1'b0;
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Monitor: predict on request acceptance, check on response acceptance.
   always @(posedge clock) begin
      lock_rsp_type got;
      lock_rsp_type want;
      accepted_flag <= 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_lock(lock_req_type'(req_tdata[42:0]));
            accepted <= accepted + 1;
            accepted_flag <= 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.kind = rsp_tdata[0];
            got.status = status_type'(rsp_tdata[3:1]);
            got.wounded_ts = rsp_tdata[35:4];
            got.last = rsp_tlast;
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected word %p", got);
            end else begin
               want = expected_rsps.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
               end
            end
         end
      end
   end

   task automatic add_req(logic func, logic [7:0] entry, logic mode, logic [31:0] ts,
                          logic wnd);
      lock_req_type q;
      q.func = func;
      q.entry = entry;
      q.mode = mode;
      q.ts = ts;
      q.wounded = wnd;
      pending_reqs.push_back(q);
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      while ((pending_reqs.size() > 0 || req_tvalid || expected_rsps.size() > 0)
             && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (20) @(posedge clock);
   endtask

   task automatic write_policy(logic [1:0] p);
      @(negedge clock);
      csr_data <= p;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      lt_policy = p;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random acquires and releases, mostly on a few hot entries, with random noise.
   task automatic random_phase(int count);
      logic [7:0] ent;
      logic [31:0] ts;
      for (int k = 0; k < count; k++) begin
         ent = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(3));
         ts = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(12));
         if ($urandom_range(19) == 0) ts = 32'hFFFF_FFF0 | 32'($urandom_range(15));
         add_req(1'($urandom_range(2) == 0), ent, 1'($urandom_range(3) == 0), ts,
                 1'($urandom_range(7) == 0));
      end
   endtask

   initial begin
      for (int e = 0; e < ENTRIES; e++) begin
         lt_count[e] = 0;
         lt_excl[e] = 1'b0;
      end
      lt_policy = POL_NO_WAIT;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: fill, full, upgrade, wrong-mode and absent releases, extremes.
      write_policy(POL_NO_WAIT);
      for (int i = 0; i < OWNERS + 1; i++) add_req(FUNC_ACQUIRE, 8'd7, 1'b0, 32'(9 - i), 1'b0);
      add_req(FUNC_ACQUIRE, 8'd7, 1'b0, 32'd5, 1'b0);
      add_req(FUNC_RELEASE, 8'd7, 1'b1, 32'd5, 1'b0);
      add_req(FUNC_RELEASE, 8'd7, 1'b0, 32'd99, 1'b0);
      add_req(FUNC_ACQUIRE, 8'd255, 1'b0, 32'hFFFF_FFFF, 1'b1);
      add_req(FUNC_ACQUIRE, 8'd255, 1'b1, 32'hFFFF_FFFF, 1'b0);
      add_req(FUNC_ACQUIRE, 8'd255, 1'b0, 32'hFFFF_FFFF, 1'b0);
      add_req(FUNC_ACQUIRE, 8'd255, 1'b1, 32'd0, 1'b0);
      add_req(FUNC_RELEASE, 8'd255, 1'b1, 32'hFFFF_FFFF, 1'b0);
      drain();
      write_policy(POL_WOUND_WAIT);
      add_req(FUNC_ACQUIRE, 8'd7, 1'b1, 32'd0, 1'b0);
      add_req(FUNC_ACQUIRE, 8'd7, 1'b1, 32'd0, 1'b1);
      add_req(FUNC_ACQUIRE, 8'd0, 1'b1, 32'd50, 1'b0);
      add_req(FUNC_ACQUIRE, 8'd0, 1'b0, 32'd10, 1'b0);
      add_req(FUNC_RELEASE, 8'd0, 1'b1, 32'd50, 1'b0);
      drain();

      write_policy(POL_WAIT_DIE);
      random_phase(100);
      drain();
      send_idle_pct = 48;
      write_policy(POL_WOUND_WAIT);
      random_phase(100);
      drain();
      send_idle_pct = 0;
      recv_stall_pct = 48;
      write_policy(2'd3);
      random_phase(90);
      drain();
      send_idle_pct = 34;
      recv_stall_pct = 34;
      write_policy(POL_NO_WAIT);
      random_phase(95);
      drain();

      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end
endmodule

[filelist.f]
hdl/rwlt_pkg.sv
hdl/rwlt_ram.sv
hdl/rw_lock_table_2pl.sv
dv/testbench.sv
